@@ rtl/layer_color_blend_macros.svh @@
// assertion macros shared by the layer color blend rtl
`ifndef LAYER_COLOR_BLEND_MACROS_SVH
`define LAYER_COLOR_BLEND_MACROS_SVH

`ifndef NO_ASSERTIONS
// property that holds at every clock edge outside reset
`define LCB_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// consequent checked in the cycle after the antecedent
`define LCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LCB_ASSERT_ALWAYS(lbl, expr, msg)
`define LCB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/lcb_pkg.sv @@
// shared types, constants and helpers for the layer color blend pipeline
package lcb_pkg;

    localparam int COLOR_W = 15;
    localparam int CHAN_W  = 5;
    localparam int NUM_CHAN = 3;
    localparam int PROD_W  = 9;
    localparam int COEF_SHIFT = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 6;

    localparam logic [CHAN_W-1:0] CH_MAX   = 5'd31;
    localparam logic [CHAN_W-1:0] COEF_MAX = 5'd16;

    localparam logic [2:0] LAYER_SPRITE = 3'd4;
    localparam logic [2:0] LAYER_LAST   = 3'd5;

    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_ALPHA    = 2'd1;
    localparam logic [1:0] MODE_BRIGHTEN = 2'd2;
    localparam logic [1:0] MODE_DARKEN   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_MASK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_WEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_WEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_STEP = 3'd5;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_ALPHA,
        OP_BRIGHTEN,
        OP_DARKEN
    } op_t;

    typedef struct packed {
        logic [5:0]        first_target_mask;
        logic [5:0]        second_target_mask;
        logic [1:0]        effect_mode;
        logic [CHAN_W-1:0] top_weight;
        logic [CHAN_W-1:0] lower_weight;
        logic [CHAN_W-1:0] brightness_step;
    } cfg_t;

    // first stage result: chosen operation and clipped coefficients
    typedef struct packed {
        op_t                op;
        logic [COLOR_W-1:0] top_color;
        logic [COLOR_W-1:0] lower_color;
        logic [CHAN_W-1:0]  top_coef;
        logic [CHAN_W-1:0]  lower_coef;
    } sel_t;

    // second stage result: per-channel products
    typedef struct packed {
        op_t                              op;
        logic [COLOR_W-1:0]               top_color;
        logic [NUM_CHAN-1:0][PROD_W-1:0]  top_prod;
        logic [NUM_CHAN-1:0][PROD_W-1:0]  lower_prod;
    } scale_t;

    function automatic logic [CHAN_W-1:0] coef_clip(input logic [CHAN_W-1:0] v);
        return (v > COEF_MAX) ? COEF_MAX : v;
    endfunction

    // layer codes above the backdrop have no mask bit
    function automatic logic mask_hit(input logic [5:0] mask, input logic [2:0] layer);
        return (layer <= LAYER_LAST) && mask[layer];
    endfunction

endpackage

@@ rtl/lcb_select.sv @@
// first pipeline stage: picks the effect for each pixel from the masks
module lcb_select (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic                        item_valid,
    input  lcb_pkg::cfg_t               cfg,
    input  logic [lcb_pkg::COLOR_W-1:0] top_color,
    input  logic [2:0]                  top_layer,
    input  logic                        top_clear,
    input  logic                        top_effects_allowed,
    input  logic                        top_semi_transparent,
    input  logic [lcb_pkg::COLOR_W-1:0] lower_color,
    input  logic [2:0]                  lower_layer,
    input  logic                        lower_clear,
    output logic                        sel_valid,
    output lcb_pkg::sel_t               sel
);

    logic          valid_reg;
    logic          valid_next;
    lcb_pkg::sel_t sel_reg;
    lcb_pkg::sel_t sel_next;
    lcb_pkg::op_t  op;
    logic          lower_ok;
    logic          forced;

    always_comb
    begin
        lower_ok = !lower_clear && lcb_pkg::mask_hit(cfg.second_target_mask, lower_layer);
        forced   = (top_layer == lcb_pkg::LAYER_SPRITE) && top_semi_transparent && lower_ok;
        if (!top_effects_allowed || top_clear)
        begin
            op = lcb_pkg::OP_PASS;
        end
        else if (forced)
        begin
            op = lcb_pkg::OP_ALPHA;
        end
        else if (!lcb_pkg::mask_hit(cfg.first_target_mask, top_layer))
        begin
            op = lcb_pkg::OP_PASS;
        end
        else
        begin
            unique case (cfg.effect_mode)
                lcb_pkg::MODE_NONE:     op = lcb_pkg::OP_PASS;
                lcb_pkg::MODE_ALPHA:    op = lower_ok ? lcb_pkg::OP_ALPHA : lcb_pkg::OP_PASS;
                lcb_pkg::MODE_BRIGHTEN: op = lcb_pkg::OP_BRIGHTEN;
                lcb_pkg::MODE_DARKEN:   op = lcb_pkg::OP_DARKEN;
            endcase
        end
    end

    always_comb
    begin
        valid_next = load ? item_valid : valid_reg;
        sel_next   = sel_reg;
        if (load && item_valid)
        begin
            sel_next.op          = op;
            sel_next.top_color   = top_color;
            sel_next.lower_color = lower_color;
            // brighten and darken share the top multiplier with the step coefficient
            sel_next.top_coef    = (op == lcb_pkg::OP_ALPHA)
                                   ? lcb_pkg::coef_clip(cfg.top_weight)
                                   : lcb_pkg::coef_clip(cfg.brightness_step);
            sel_next.lower_coef  = lcb_pkg::coef_clip(cfg.lower_weight);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
    end

    assign sel_valid = valid_reg;
    assign sel       = sel_reg;

endmodule

@@ rtl/lcb_scale.sv @@
// second pipeline stage: per-channel coefficient multiplies
module lcb_scale (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  logic            sel_valid,
    input  lcb_pkg::sel_t   sel,
    output logic            scale_valid,
    output lcb_pkg::scale_t scale
);

    localparam int W = lcb_pkg::CHAN_W;

    logic            valid_reg;
    logic            valid_next;
    lcb_pkg::scale_t scale_reg;
    lcb_pkg::scale_t scale_next;
    logic [lcb_pkg::NUM_CHAN-1:0][lcb_pkg::PROD_W-1:0] top_prod;
    logic [lcb_pkg::NUM_CHAN-1:0][lcb_pkg::PROD_W-1:0] lower_prod;

    always_comb
    begin
        logic [W-1:0]   x;
        logic [W-1:0]   y;
        logic [W-1:0]   mul_in;
        logic [2*W-1:0] p_top;
        logic [2*W-1:0] p_low;
        for (int k = 0; k < lcb_pkg::NUM_CHAN; k++)
        begin
            x      = sel.top_color[k*W +: W];
            y      = sel.lower_color[k*W +: W];
            // brighten scales the distance to white
            mul_in = (sel.op == lcb_pkg::OP_BRIGHTEN) ? (lcb_pkg::CH_MAX - x) : x;
            p_top  = {{W{1'b0}}, mul_in} * {{W{1'b0}}, sel.top_coef};
            p_low  = {{W{1'b0}}, y} * {{W{1'b0}}, sel.lower_coef};
            top_prod[k]   = p_top[lcb_pkg::PROD_W-1:0];
            lower_prod[k] = p_low[lcb_pkg::PROD_W-1:0];
        end
    end

    always_comb
    begin
        valid_next = load ? sel_valid : valid_reg;
        scale_next = scale_reg;
        if (load && sel_valid)
        begin
            scale_next.op         = sel.op;
            scale_next.top_color  = sel.top_color;
            scale_next.top_prod   = top_prod;
            scale_next.lower_prod = lower_prod;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scale_reg <= scale_next;
    end

    assign scale_valid = valid_reg;
    assign scale       = scale_reg;

endmodule

@@ rtl/lcb_merge.sv @@
// third pipeline stage: shift, add or subtract, saturate, output register
`include "layer_color_blend_macros.svh"

module lcb_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic                        scale_valid,
    input  lcb_pkg::scale_t             scale,
    output logic                        pix_valid,
    output logic [lcb_pkg::COLOR_W-1:0] pixel_color
);

    localparam int W = lcb_pkg::CHAN_W;

    logic                        valid_reg;
    logic                        valid_next;
    logic [lcb_pkg::COLOR_W-1:0] pixel_reg;
    logic [lcb_pkg::COLOR_W-1:0] pixel_next;
    logic [lcb_pkg::COLOR_W-1:0] blended;

    always_comb
    begin
        logic [W-1:0] x;
        logic [W-1:0] q_top;
        logic [W-1:0] q_low;
        logic [W:0]   sum;
        logic [W-1:0] n;
        for (int k = 0; k < lcb_pkg::NUM_CHAN; k++)
        begin
            x     = scale.top_color[k*W +: W];
            q_top = scale.top_prod[k][lcb_pkg::PROD_W-1:lcb_pkg::COEF_SHIFT];
            q_low = scale.lower_prod[k][lcb_pkg::PROD_W-1:lcb_pkg::COEF_SHIFT];
            sum   = {1'b0, x} + {1'b0, q_top};
            n     = x;
            case (scale.op)
                lcb_pkg::OP_ALPHA:
                begin
                    sum = {1'b0, q_top} + {1'b0, q_low};
                    n   = (sum > {1'b0, lcb_pkg::CH_MAX}) ? lcb_pkg::CH_MAX : sum[W-1:0];
                end
                // never passes white since the product is at most the distance
                lcb_pkg::OP_BRIGHTEN: n = sum[W-1:0];
                lcb_pkg::OP_DARKEN:   n = x - q_top;
                default:              n = x;
            endcase
            blended[k*W +: W] = n;
        end
    end

    always_comb
    begin
        valid_next = load ? scale_valid : valid_reg;
        pixel_next = (load && scale_valid) ? blended : pixel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
    end

    assign pix_valid   = valid_reg;
    assign pixel_color = pixel_reg;

    `LCB_ASSERT_NEXT(a_darken_red_le, load && scale_valid && scale.op == lcb_pkg::OP_DARKEN, pixel_reg[4:0] <= $past(scale.top_color[4:0]), "darken raised red")
    `LCB_ASSERT_NEXT(a_brighten_blue_ge, load && scale_valid && scale.op == lcb_pkg::OP_BRIGHTEN, pixel_reg[14:10] >= $past(scale.top_color[14:10]), "brighten lowered blue")
    `LCB_ASSERT_NEXT(a_pass_keeps, load && scale_valid && scale.op == lcb_pkg::OP_PASS, pixel_reg == $past(scale.top_color), "pass changed color")

endmodule

@@ rtl/layer_color_blend.sv @@
// top level of the layer color blend pipeline with its configuration registers
// an accepted input passes the select, multiply and merge registers to the output
// throughput: one pixel per cycle unless stalled, via select, multiply, merge stages
// a stall holds only the stages that are full, so empty stages still fill up
// reset clears all configuration registers to zero and empties the pipeline
// the configuration port is always ready and takes one write per cycle
`include "layer_color_blend_macros.svh"

module layer_color_blend (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [lcb_pkg::COLOR_W-1:0]    top_color,
    input  logic [2:0]                     top_layer,
    input  logic                           top_clear,
    input  logic                           top_effects_allowed,
    input  logic                           top_semi_transparent,
    input  logic [lcb_pkg::COLOR_W-1:0]    lower_color,
    input  logic [2:0]                     lower_layer,
    input  logic                           lower_clear,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [lcb_pkg::COLOR_W-1:0]    pixel_color,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lcb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lcb_pkg::CFG_DATA_W-1:0] cfg_data
);

    lcb_pkg::cfg_t   cfg_reg;
    lcb_pkg::cfg_t   cfg_next;
    logic            load1;
    logic            load2;
    logic            load3;
    logic            s1_valid;
    lcb_pkg::sel_t   s1_data;
    logic            s2_valid;
    lcb_pkg::scale_t s2_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lcb_pkg::REG_FIRST_MASK:   cfg_next.first_target_mask  = cfg_data;
                lcb_pkg::REG_SECOND_MASK:  cfg_next.second_target_mask = cfg_data;
                lcb_pkg::REG_EFFECT_MODE:  cfg_next.effect_mode        = cfg_data[1:0];
                lcb_pkg::REG_TOP_WEIGHT:   cfg_next.top_weight         = cfg_data[4:0];
                lcb_pkg::REG_LOWER_WEIGHT: cfg_next.lower_weight       = cfg_data[4:0];
                lcb_pkg::REG_BRIGHT_STEP:  cfg_next.brightness_step    = cfg_data[4:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // a stage loads when it is empty or the stage after it moves on
    assign load3    = !out_valid || !out_stall;
    assign load2    = !s2_valid || load3;
    assign load1    = !s1_valid || load2;
    assign in_stall = !load1;

    lcb_select u_select (
        .clk                  (clk),
        .rst_n                (rst_n),
        .load                 (load1),
        .item_valid           (in_valid),
        .cfg                  (cfg_reg),
        .top_color            (top_color),
        .top_layer            (top_layer),
        .top_clear            (top_clear),
        .top_effects_allowed  (top_effects_allowed),
        .top_semi_transparent (top_semi_transparent),
        .lower_color          (lower_color),
        .lower_layer          (lower_layer),
        .lower_clear          (lower_clear),
        .sel_valid            (s1_valid),
        .sel                  (s1_data)
    );

    lcb_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load2),
        .sel_valid   (s1_valid),
        .sel         (s1_data),
        .scale_valid (s2_valid),
        .scale       (s2_data)
    );

    lcb_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load3),
        .scale_valid (s2_valid),
        .scale       (s2_data),
        .pix_valid   (out_valid),
        .pixel_color (pixel_color)
    );

    `LCB_ASSERT_ALWAYS(a_stall_only_full, !in_stall || (s1_valid && s2_valid && out_valid && out_stall), "input stalled with room in the pipeline")
    `LCB_ASSERT_NEXT(a_stalled_item_kept, s2_valid && !load2, s2_valid, "held item lost in multiply stage")

endmodule
